/* rtl/core/nsf_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA sentence framer package
// Shared constants, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned CAP_W         = 7;
   localparam int unsigned STORE_DEPTH_D = 64;

   localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;

   localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/nsf_if.sv */
// ----------------------------------------------------------------------------
// NMEA sentence framer channels
// Valid/ready channel interfaces for received bytes, sentence bytes and the
// capacity register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsf_req_if;
   logic                          valid;
   logic                          ready;
   logic [nsf_pkg::BYTE_W-1:0]    rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nsf_pkg::BYTE_W-1:0]    line_byte;
   logic                          line_last;
   modport source (output valid, output line_byte, output line_last, input ready);
   modport sink   (input valid, input line_byte, input line_last, output ready);
endinterface

interface nsf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [nsf_pkg::CAP_W-1:0]     max_buffer_bytes;
   modport source (output valid, output max_buffer_bytes, input ready);
   modport sink   (input valid, input max_buffer_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/nsf_store.sv */
// ----------------------------------------------------------------------------
// NMEA sentence store
// Simple dual-port byte memory holding the sentence in progress, with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_store #(
   parameter  int unsigned DEPTH = nsf_pkg::STORE_DEPTH_D,
   localparam int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [nsf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [nsf_pkg::BYTE_W-1:0] rd_data
);

   logic [nsf_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [nsf_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/nmea_sentence_framer_unit.sv */
// ----------------------------------------------------------------------------
// NMEA sentence framer
// Collects received bytes into sentences from '$' to newline and sends each
// completed sentence out as a burst of bytes with the last byte marked.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one received byte per transfer. Bytes outside a
// sentence are discarded, and each '$' restarts collection. A byte that does
// not end a sentence leaves the block ready again at once. A newline that
// completes a sentence starts a burst on the rsp channel: each sentence
// byte is read from the store and presented in the next cycle, and is
// held until the receiver takes it. One trailing carriage return is left
// out, and line_last marks the final byte. The req channel is not ready
// during the burst. The csr channel writes the capacity register, whose
// value is clamped to 1..STORE_DEPTH when used; a sentence longer than
// the capacity, counted through its newline, is dropped. Reset returns the
// block to hunting for '$' with capacity 64 and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer_unit #(
   parameter int unsigned STORE_DEPTH = nsf_pkg::STORE_DEPTH_D
) (
   input wire logic  clock,
   input wire logic  reset,
   nsf_req_if.sink   req_ch,
   nsf_rsp_if.source rsp_ch,
   nsf_csr_if.sink   csr_ch
);

   localparam int unsigned AW    = $clog2(STORE_DEPTH);
   localparam int unsigned LEN_W = $clog2(STORE_DEPTH + 1);
   localparam int unsigned CMP_W = ((LEN_W > nsf_pkg::CAP_W) ? LEN_W : nsf_pkg::CAP_W) + 1;

   nsf_pkg::state_type          state_ff, state_in;
   logic [nsf_pkg::CAP_W-1:0]   cap_ff;
   logic [LEN_W-1:0]            idx_ff, idx_in;
   logic                        in_sent_ff, in_sent_in;
   logic                        last_cr_ff, last_cr_in;
   logic [AW-1:0]               end_ff, end_in;
   logic                        rd_last_ff, rd_last_in;

   logic [CMP_W-1:0]            cap_ext;
   logic [CMP_W-1:0]            cap_eff;
   logic [CMP_W-1:0]            len_plus;
   logic [LEN_W-1:0]            idx_inc;
   logic [LEN_W-1:0]            end_len;
   logic                        req_xfer;
   logic                        rsp_xfer;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [nsf_pkg::BYTE_W-1:0]  rd_data;

   nsf_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= nsf_pkg::CAP_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         cap_ff <= csr_ch.max_buffer_bytes;
      end
   end

   assign cap_ext  = CMP_W'(cap_ff);
   assign cap_eff  = (cap_ff == '0) ? CMP_W'(1) :
                     ((cap_ext > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH) : cap_ext);
   assign idx_inc  = idx_ff + LEN_W'(1);
   assign len_plus = CMP_W'(idx_ff) + CMP_W'(1);
   assign end_len  = (idx_ff > LEN_W'(1) && last_cr_ff) ? (idx_ff - LEN_W'(2))
                                                         : (idx_ff - LEN_W'(1));

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= nsf_pkg::ST_IDLE;
         idx_ff     <= '0;
         in_sent_ff <= 1'b0;
         last_cr_ff <= 1'b0;
         end_ff     <= '0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         in_sent_ff <= in_sent_in;
         last_cr_ff <= last_cr_in;
         end_ff     <= end_in;
         rd_last_ff <= rd_last_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      in_sent_in   = in_sent_ff;
      last_cr_in   = last_cr_ff;
      end_in       = end_ff;
      rd_last_in   = rd_last_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      rd_en        = 1'b0;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      case (state_ff)
         nsf_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.rx_byte == nsf_pkg::CH_DOLLAR) begin
                  wr_en      = 1'b1;
                  wr_addr    = '0;
                  idx_in     = LEN_W'(1);
                  in_sent_in = 1'b1;
                  last_cr_in = 1'b0;
               end else if (in_sent_ff) begin
                  if (len_plus > cap_eff) begin
                     idx_in     = '0;
                     in_sent_in = 1'b0;
                  end else if (req_ch.rx_byte != nsf_pkg::CH_LF) begin
                     wr_en      = 1'b1;
                     idx_in     = idx_inc;
                     last_cr_in = (req_ch.rx_byte == nsf_pkg::CH_CR);
                  end else begin
                     end_in     = end_len[AW-1:0];
                     idx_in     = '0;
                     in_sent_in = 1'b0;
                     state_in   = nsf_pkg::ST_READ;
                  end
               end
            end
         end
         nsf_pkg::ST_READ: begin
            rd_en      = 1'b1;
            rd_last_in = (idx_ff[AW-1:0] == end_ff);
            state_in   = nsf_pkg::ST_SEND;
         end
         nsf_pkg::ST_SEND: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               if (rd_last_ff) begin
                  idx_in   = '0;
                  state_in = nsf_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = nsf_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = nsf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.line_byte = rd_data;
   assign rsp_ch.line_last = rd_last_ff;

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == nsf_pkg::ST_READ |=> state_ff == nsf_pkg::ST_SEND)
      else $error("store read was not followed by a presented byte");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_ch.line_last |=> state_ff == nsf_pkg::ST_IDLE && idx_ff == '0)
      else $error("burst did not end after its last byte");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(idx_ff) <= CMP_W'(STORE_DEPTH))
      else $error("stored sentence length exceeds the store depth");

   a_hunt_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == nsf_pkg::ST_IDLE && !in_sent_ff |-> idx_ff == '0)
      else $error("length not cleared while hunting");

   a_dollar_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_ch.rx_byte == nsf_pkg::CH_DOLLAR |=> in_sent_ff && idx_ff == LEN_W'(1))
      else $error("start character did not open a sentence");

endmodule

`default_nettype wire

/* bench/nmea_sentence_framer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence framer testbench
// Drives received bytes into the framer and checks every sentence byte that
// comes out against a predictor of the framing, restart, carriage return and
// capacity rules. Both channels idle at random, and the capacity register is
// written between phases while the block is idle.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_unit_tb;

   localparam int unsigned BUF_AW = $clog2(nsf_pkg::STORE_DEPTH_D);

   typedef enum {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_mode_type;

   typedef struct packed {
      logic [nsf_pkg::BYTE_W-1:0] line_byte;
      logic                       line_last;
   } line_beat_type;

   typedef logic [nsf_pkg::BYTE_W-1:0] byte_q_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;

   nsf_req_if req_ch ();
   nsf_rsp_if rsp_ch ();
   nsf_csr_if csr_ch ();

   nmea_sentence_framer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [nsf_pkg::BYTE_W-1:0] sentence_buf [nsf_pkg::STORE_DEPTH_D];
   int unsigned                sentence_len = 0;
   bit                         collecting = 1'b0;
   logic [nsf_pkg::CAP_W-1:0]  cap_reg = nsf_pkg::CAP_RESET;
   line_beat_type              framed_lines[$];

   int            error_count = 0;
   int            hold_off_cycles = 0;
   pace_mode_type send_pace = PACE_RANDOM;
   pace_mode_type rcv_pace = PACE_RANDOM;

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("nmea_sentence_framer_unit_tb: errors");
      $finish;
   end

   function automatic int pick_gap(pace_mode_type m);
      case (m)
         PACE_FULL:   return 0;
         PACE_RANDOM: return $urandom_range(0, 18);
         default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   function automatic void frame_byte(logic [nsf_pkg::BYTE_W-1:0] b);
      int unsigned cap;
      int unsigned n;
      cap = 32'(cap_reg);
      if (cap == 0) cap = 1;
      if (cap > nsf_pkg::STORE_DEPTH_D) cap = nsf_pkg::STORE_DEPTH_D;
      if (b == nsf_pkg::CH_DOLLAR) begin
         sentence_buf[0] = b;
         sentence_len = 1;
         collecting = 1'b1;
         if (sentence_len > cap) begin
            collecting = 1'b0;
            sentence_len = 0;
         end
         return;
      end
      if (!collecting) return;
      if (sentence_len + 1 > cap) begin
         collecting = 1'b0;
         sentence_len = 0;
         return;
      end
      if (b != nsf_pkg::CH_LF) begin
         sentence_buf[BUF_AW'(sentence_len)] = b;
         sentence_len++;
         return;
      end
      n = sentence_len;
      if (n > 1 && sentence_buf[BUF_AW'(n - 1)] == nsf_pkg::CH_CR) n--;
      for (int i = 0; i < n; i++) begin
         framed_lines.push_back('{line_byte: sentence_buf[BUF_AW'(i)],
                                  line_last: (i + 1 == n)});
      end
      collecting = 1'b0;
      sentence_len = 0;
   endfunction

   function automatic logic [nsf_pkg::BYTE_W-1:0] body_byte();
      logic [nsf_pkg::BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == nsf_pkg::CH_DOLLAR || b == nsf_pkg::CH_LF);
      return b;
   endfunction

   function automatic byte_q_type make_sentence(int body_len, bit with_cr);
      byte_q_type s;
      s.push_back(nsf_pkg::CH_DOLLAR);
      repeat (body_len) s.push_back(body_byte());
      if (with_cr) s.push_back(nsf_pkg::CH_CR);
      s.push_back(nsf_pkg::CH_LF);
      return s;
   endfunction

   task automatic send_byte(logic [nsf_pkg::BYTE_W-1:0] b);
      int gap;
      gap = pick_gap(send_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      frame_byte(b);
   endtask

   task automatic send_bytes(byte_q_type s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain_results();
      int waited;
      idle_req();
      waited = 0;
      while (framed_lines.size() != 0 && waited < 40000) begin
         @(posedge clock);
         waited++;
      end
      if (framed_lines.size() != 0) begin
         error_count++;
         $display("%0t: %0d sentence bytes never arrived", $time, framed_lines.size());
         framed_lines.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_capacity(logic [nsf_pkg::CAP_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_ch.valid            <= 1'b1;
      csr_ch.max_buffer_bytes <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      cap_reg = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_framing();
      send_pace = PACE_RANDOM;
      send_bytes('{nsf_pkg::CH_LF, 8'hFF});
      send_bytes('{nsf_pkg::CH_DOLLAR, 8'h00, 8'hFF, nsf_pkg::CH_CR, nsf_pkg::CH_LF});
      send_bytes('{nsf_pkg::CH_DOLLAR, nsf_pkg::CH_CR, nsf_pkg::CH_LF});
      send_bytes('{nsf_pkg::CH_DOLLAR, nsf_pkg::CH_CR, 8'h41, nsf_pkg::CH_CR,
                   nsf_pkg::CH_CR, nsf_pkg::CH_LF});
      send_bytes('{nsf_pkg::CH_DOLLAR, 8'h42, nsf_pkg::CH_DOLLAR, nsf_pkg::CH_LF});
      drain_results();
   endtask

   task automatic test_capacity_limits();
      send_pace = PACE_SPARSE;
      write_capacity(7'd0);
      send_bytes('{nsf_pkg::CH_DOLLAR, nsf_pkg::CH_LF, nsf_pkg::CH_DOLLAR, 8'h41,
                   nsf_pkg::CH_LF});
      write_capacity(7'd1);
      send_bytes('{nsf_pkg::CH_DOLLAR, nsf_pkg::CH_LF});
      write_capacity(7'd2);
      send_bytes('{nsf_pkg::CH_DOLLAR, nsf_pkg::CH_LF, nsf_pkg::CH_DOLLAR, 8'h41,
                   nsf_pkg::CH_LF});
      write_capacity(7'd127);
      send_bytes(make_sentence(62, 1'b0));
      send_bytes(make_sentence(63, 1'b0));
      send_bytes('{8'h58, nsf_pkg::CH_LF});
      write_capacity(7'd5);
      send_bytes(make_sentence(3, 1'b0));
      send_bytes(make_sentence(3, 1'b1));
      drain_results();
   endtask

   task automatic test_backpressure();
      write_capacity(7'd64);
      send_pace = PACE_FULL;
      hold_off_cycles = 300;
      send_bytes(make_sentence(20, 1'b0));
      send_bytes(make_sentence(25, 1'b1));
      drain_results();
   endtask

   task automatic test_random_traffic();
      byte_q_type s;
      int         sent;
      int         len;
      logic [nsf_pkg::CAP_W-1:0] cap;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       cap = 7'd64;
            1:       cap = 7'($urandom_range(1, 16));
            2:       cap = 7'd127;
            3:       cap = 7'($urandom_range(17, 63));
            4:       cap = 7'd3;
            default: cap = 7'($urandom_range(0, 127));
         endcase
         write_capacity(cap);
         sent = 0;
         while (sent < 8) begin
            send_pace = pace_mode_type'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
            s = make_sentence(len, $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
               0:       s.delete(s.size() - 1);
               1:       s.insert($urandom_range(1, s.size() - 1), nsf_pkg::CH_DOLLAR);
               default: ;
            endcase
            send_bytes(s);
            sent += s.size();
            if ($urandom_range(0, 19) == 0) drain_results();
         end
      end
      drain_results();
   endtask

   initial begin : line_receiver
      int            stall;
      int            beats;
      line_beat_type want;
      rsp_ch.ready <= 1'b0;
      beats = 0;
      wait (reset === 1'b0);
      forever begin
         if (beats % 40 == 0) rcv_pace = pace_mode_type'($urandom_range(0, 2));
         stall = pick_gap(rcv_pace);
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         beats++;
         if (framed_lines.size() == 0) begin
            error_count++;
            $display("%0t: unexpected sentence byte %02h last %0b",
                     $time, rsp_ch.line_byte, rsp_ch.line_last);
         end else begin
            want = framed_lines.pop_front();
            if (rsp_ch.line_byte !== want.line_byte) begin
               error_count++;
               $display("%0t: line_byte expected %02h, got %02h",
                        $time, want.line_byte, rsp_ch.line_byte);
            end
            if (rsp_ch.line_last !== want.line_last) begin
               error_count++;
               $display("%0t: line_last expected %0b, got %0b",
                        $time, want.line_last, rsp_ch.line_last);
            end
         end
      end
   end

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.rx_byte          <= '0;
      csr_ch.valid            <= 1'b0;
      csr_ch.max_buffer_bytes <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_framing();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("nmea_sentence_framer_unit_tb: clean");
      end else begin
         $display("nmea_sentence_framer_unit_tb: errors");
      end
      $finish;
   end

endmodule

/* nmea_sentence_framer_unit.f */
rtl/core/nsf_pkg.sv
rtl/core/nsf_if.sv
rtl/core/nsf_store.sv
rtl/core/nmea_sentence_framer_unit.sv
bench/nmea_sentence_framer_unit_tb.sv
